// ===== hw/rtl/evr_pkg.sv =====
// Shared types and constants for the Euler XYZ vector rotation block.
package evr_pkg;

    localparam int CS_WIDTH    = 32;          // CORDIC word, 30 fraction bits
    localparam int FRAC_BITS   = 30;
    localparam int ATAN_MAX    = 24;          // atan table depth
    localparam int TURN_BITS   = 32;          // internal binary angle width
    localparam logic signed [CS_WIDTH-1:0] CORDIC_GAIN = 32'sd652032874;

    typedef struct packed {
        logic signed [CS_WIDTH-1:0] x;
        logic signed [CS_WIDTH-1:0] y;
        logic signed [CS_WIDTH-1:0] z;
        logic [1:0]                 quad;
    } cordic_t;

    typedef struct packed {
        logic signed [CS_WIDTH-1:0] c;
        logic signed [CS_WIDTH-1:0] s;
    } cs_t;

    // atan(2^-i) in units of 2^32 per turn
    function automatic logic signed [CS_WIDTH-1:0] atan_turns(input logic [4:0] i);
        logic signed [CS_WIDTH-1:0] r;
        case (i)
            5'd0:    r = 32'sd536870912;
            5'd1:    r = 32'sd316933406;
            5'd2:    r = 32'sd167458907;
            5'd3:    r = 32'sd85004756;
            5'd4:    r = 32'sd42667331;
            5'd5:    r = 32'sd21354465;
            5'd6:    r = 32'sd10679838;
            5'd7:    r = 32'sd5340245;
            5'd8:    r = 32'sd2670163;
            5'd9:    r = 32'sd1335087;
            5'd10:   r = 32'sd667544;
            5'd11:   r = 32'sd333772;
            5'd12:   r = 32'sd166886;
            5'd13:   r = 32'sd83443;
            5'd14:   r = 32'sd41722;
            5'd15:   r = 32'sd20861;
            5'd16:   r = 32'sd10430;
            5'd17:   r = 32'sd5215;
            5'd18:   r = 32'sd2608;
            5'd19:   r = 32'sd1304;
            5'd20:   r = 32'sd652;
            5'd21:   r = 32'sd326;
            5'd22:   r = 32'sd163;
            5'd23:   r = 32'sd81;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/evr_cordic_cell.sv =====
// One CORDIC rotation cell: a single micro-rotation, registered.
module evr_cordic_cell
    import evr_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic    clk,
    input  cordic_t d,
    output cordic_t q
);

    localparam logic signed [CS_WIDTH-1:0] ATAN = atan_turns(5'(STAGE));

    cordic_t q_reg;
    cordic_t q_next;
    logic signed [CS_WIDTH-1:0] dx;
    logic signed [CS_WIDTH-1:0] dy;

    always_comb
    begin
        dx = $signed(d.y) >>> STAGE;
        dy = $signed(d.x) >>> STAGE;
        q_next.quad = d.quad;
        if (!d.z[CS_WIDTH-1])
        begin
            q_next.x = $signed(d.x) - dx;
            q_next.y = $signed(d.y) + dy;
            q_next.z = $signed(d.z) - ATAN;
        end
        else
        begin
            q_next.x = $signed(d.x) + dx;
            q_next.y = $signed(d.y) - dy;
            q_next.z = $signed(d.z) + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end

    assign q = q_reg;

endmodule

// ===== hw/rtl/evr_plane_rot.sv =====
// Plane rotation (a,b) -> (a*c-b*s, a*s+b*c), rounded and saturated, registered.
module evr_plane_rot
    import evr_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)
(
    input  logic                          clk,
    input  logic signed [COORD_WIDTH-1:0] a,
    input  logic signed [COORD_WIDTH-1:0] b,
    input  cs_t                           cs,
    output logic signed [COORD_WIDTH-1:0] na,
    output logic signed [COORD_WIDTH-1:0] nb
);

    localparam int PW = COORD_WIDTH + CS_WIDTH;
    localparam int SW = PW + 1;
    localparam int RW = SW - FRAC_BITS;

    logic signed [PW-1:0] ac_reg, bs_reg, as_reg, bc_reg;
    logic signed [SW-1:0] sum_a, sum_b;
    logic signed [COORD_WIDTH-1:0] na_reg, nb_reg;
    logic signed [COORD_WIDTH-1:0] na_next, nb_next;

    function automatic logic signed [COORD_WIDTH-1:0] scale_back(
        input logic signed [SW-1:0] s);
        logic signed [SW-1:0] r;
        logic signed [RW-1:0] t;
        logic signed [RW-1:0] hi;
        logic signed [RW-1:0] lo;
        r  = s + (SW'(1) <<< (FRAC_BITS - 1));
        t  = RW'(r >>> FRAC_BITS);
        hi = RW'({1'b0, {(COORD_WIDTH-1){1'b1}}});
        lo = -hi - RW'(1);
        if (t > hi)
            return hi[COORD_WIDTH-1:0];
        else if (t < lo)
            return lo[COORD_WIDTH-1:0];
        else
            return t[COORD_WIDTH-1:0];
    endfunction

    always_ff @(posedge clk)
    begin
        ac_reg <= PW'(a) * PW'(cs.c);
        bs_reg <= PW'(b) * PW'(cs.s);
        as_reg <= PW'(a) * PW'(cs.s);
        bc_reg <= PW'(b) * PW'(cs.c);
    end

    always_comb
    begin
        sum_a   = SW'(ac_reg) - SW'(bs_reg);
        sum_b   = SW'(as_reg) + SW'(bc_reg);
        na_next = scale_back(sum_a);
        nb_next = scale_back(sum_b);
    end

    always_ff @(posedge clk)
    begin
        na_reg <= na_next;
        nb_reg <= nb_next;
    end

    assign na = na_reg;
    assign nb = nb_reg;

endmodule

// ===== hw/rtl/euler_xyz_vector_rotation_top.sv =====
// Top level of the Euler XYZ vector rotation pipeline.
//
// Usage: drive vec_x/y/z and angle_x/y/z with start high; the transaction is
// taken at any rising edge where start is high and busy is low. busy is low
// whenever reset is released, so a new transaction may enter every cycle.
// The vector is rotated about X, then Y, then Z (binary angles, a full turn
// is 2^ANGLE_WIDTH), rounding half up and saturating after each plane step.
// Results appear on out_x/y/z for exactly one cycle with done high.
// Throughput: one transaction per cycle. Sine/cosine for all three angles come
// from three parallel rows of NS CORDIC cells (ROTATION_STAGES, capped at
// ATAN_MAX); each plane step is a unit with its products registered, then
// sum/round/saturate registered.
// Reset clears the done strobe pipeline only; transactions in flight are
// dropped. The receiver cannot stall, so nothing ever backs up.
module euler_xyz_vector_rotation_top
    import evr_pkg::*;
#(
    parameter int COORD_WIDTH     = 24,
    parameter int ANGLE_WIDTH     = 16,
    parameter int ROTATION_STAGES = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] vec_x,
    input  logic signed [COORD_WIDTH-1:0] vec_y,
    input  logic signed [COORD_WIDTH-1:0] vec_z,
    input  logic [ANGLE_WIDTH-1:0]        angle_x,
    input  logic [ANGLE_WIDTH-1:0]        angle_y,
    input  logic [ANGLE_WIDTH-1:0]        angle_z,
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic signed [COORD_WIDTH-1:0] out_z
);

    // CORDIC row length, capped at the atan table depth
    localparam int NS  = (ROTATION_STAGES > ATAN_MAX) ? ATAN_MAX : ROTATION_STAGES;
    localparam int LAT = NS + 6;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
    } vec_t;

    logic accept;
    logic [LAT-1:0] valid_reg;

    cordic_t row_x [0:NS];
    cordic_t row_y [0:NS];
    cordic_t row_z [0:NS];
    vec_t    vec_reg [0:NS-1];

    cs_t cs_x, cs_y, cs_z;
    cs_t cs_y_reg [0:1];
    cs_t cs_z_reg [0:3];

    logic signed [COORD_WIDTH-1:0] x_d_reg [0:1];
    logic signed [COORD_WIDTH-1:0] y1, z1, z2, x2, x3, y3;
    logic signed [COORD_WIDTH-1:0] y1_d_reg [0:1];
    logic signed [COORD_WIDTH-1:0] z2_d_reg [0:1];

    // Quadrant unfold: residual angle gives (x,y) = (cos,sin) in the first quadrant
    function automatic cs_t unfold(input cordic_t r);
        cs_t o;
        case (r.quad)
            2'd0:    begin o.c =  r.x; o.s =  r.y; end
            2'd1:    begin o.c = -r.y; o.s =  r.x; end
            2'd2:    begin o.c = -r.x; o.s = -r.y; end
            default: begin o.c =  r.y; o.s = -r.x; end
        endcase
        return o;
    endfunction

    // Seed a CORDIC row: angle scaled to 2^32 per turn, top two bits = quadrant
    function automatic cordic_t seed(input logic [ANGLE_WIDTH-1:0] ang);
        cordic_t s;
        logic [TURN_BITS-1:0] a;
        a      = {ang, {(TURN_BITS-ANGLE_WIDTH){1'b0}}};
        s.x    = CORDIC_GAIN;
        s.y    = '0;
        s.z    = {2'b00, a[TURN_BITS-3:0]};
        s.quad = a[TURN_BITS-1:TURN_BITS-2];
        return s;
    endfunction

    assign busy   = ~rst_n;
    assign accept = start & ~busy;

    assign row_x[0] = seed(angle_x);
    assign row_y[0] = seed(angle_y);
    assign row_z[0] = seed(angle_z);

    // Three parallel rows of CORDIC cells
    for (genvar k = 0; k < NS; k++)
    begin : g_row
        evr_cordic_cell #(.STAGE(k)) u_cx (.clk(clk), .d(row_x[k]), .q(row_x[k+1]));
        evr_cordic_cell #(.STAGE(k)) u_cy (.clk(clk), .d(row_y[k]), .q(row_y[k+1]));
        evr_cordic_cell #(.STAGE(k)) u_cz (.clk(clk), .d(row_z[k]), .q(row_z[k+1]));
    end

    // Vector rides alongside the CORDIC rows
    always_ff @(posedge clk)
    begin
        vec_reg[0] <= '{x: vec_x, y: vec_y, z: vec_z};
        for (int i = 1; i < NS; i++)
            vec_reg[i] <= vec_reg[i-1];
    end

    assign cs_x = unfold(row_x[NS]);
    assign cs_y = unfold(row_y[NS]);
    assign cs_z = unfold(row_z[NS]);

    // Align coefficients and pass-through coordinates with the plane units
    always_ff @(posedge clk)
    begin
        cs_y_reg[0] <= cs_y;
        cs_y_reg[1] <= cs_y_reg[0];
        cs_z_reg[0] <= cs_z;
        for (int i = 1; i < 4; i++)
            cs_z_reg[i] <= cs_z_reg[i-1];
        x_d_reg[0]  <= vec_reg[NS-1].x;
        x_d_reg[1]  <= x_d_reg[0];
        y1_d_reg[0] <= y1;
        y1_d_reg[1] <= y1_d_reg[0];
        z2_d_reg[0] <= z2;
        z2_d_reg[1] <= z2_d_reg[0];
    end

    // About X: (y,z)
    evr_plane_rot #(.COORD_WIDTH(COORD_WIDTH)) u_rot_x (
        .clk(clk), .a(vec_reg[NS-1].y), .b(vec_reg[NS-1].z), .cs(cs_x),
        .na(y1), .nb(z1));

    // About Y: (z,x)
    evr_plane_rot #(.COORD_WIDTH(COORD_WIDTH)) u_rot_y (
        .clk(clk), .a(z1), .b(x_d_reg[1]), .cs(cs_y_reg[1]),
        .na(z2), .nb(x2));

    // About Z: (x,y)
    evr_plane_rot #(.COORD_WIDTH(COORD_WIDTH)) u_rot_z (
        .clk(clk), .a(x2), .b(y1_d_reg[1]), .cs(cs_z_reg[3]),
        .na(x3), .nb(y3));

    // Strobe pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= {valid_reg[LAT-2:0], accept};
    end

    assign done  = valid_reg[LAT-1];
    assign out_x = x3;
    assign out_y = y3;
    assign out_z = z2_d_reg[1];

endmodule

// ===== hw/rtl/evr_chk.sv =====
// Port-level checker for the Euler XYZ rotation block, with its bind.
module evr_chk #(
    parameter int LATENCY = 22
)
(
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy high out of reset");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted transaction produced no result");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching transaction");

endmodule

bind euler_xyz_vector_rotation_top evr_chk #(
    .LATENCY(((ROTATION_STAGES > 24) ? 24 : ROTATION_STAGES) + 6)
) u_evr_chk (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .done(done)
);
